// ----- design/asrk_pkg.sv -----
// Shared types, register indexes and helpers for the keyed ShiftRows block.
// No dependencies; the rank, permute and top-level modules import it.
package asrk_pkg;

	localparam int unsigned NumWords = 4;
	localparam int unsigned WordW    = 32;
	localparam int unsigned RankW    = 2;

	typedef enum logic [0:0] {
		CFG_KEYED_MODE = 1'b0,
		CFG_INVERSE    = 1'b1
	} cfg_idx_e;

	typedef struct packed {
		logic keyed_mode;
		logic inverse;
	} cfg_t;

	typedef struct packed {
		logic [WordW-1:0] state_word_0;
		logic [WordW-1:0] state_word_1;
		logic [WordW-1:0] state_word_2;
		logic [WordW-1:0] state_word_3;
		logic [WordW-1:0] key_word_0;
		logic [WordW-1:0] key_word_1;
		logic [WordW-1:0] key_word_2;
		logic [WordW-1:0] key_word_3;
	} item_t;

	typedef struct packed {
		logic [WordW-1:0] out_word_0;
		logic [WordW-1:0] out_word_1;
		logic [WordW-1:0] out_word_2;
		logic [WordW-1:0] out_word_3;
	} result_t;

	typedef logic [NumWords-1:0][WordW-1:0] word_arr_t;
	typedef logic [NumWords-1:0][RankW-1:0] rank_arr_t;

	// XOR of the four bytes of a word
	function automatic logic [7:0] fold_bytes(input logic [WordW-1:0] w);
		return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
	endfunction

endpackage

// ----- design/asrk_rank.sv -----
// Rank of each word by the byte fold of state XOR key.
// Depends on asrk_pkg.
module asrk_rank (
	input  asrk_pkg::word_arr_t state_words,
	input  asrk_pkg::word_arr_t key_words,
	output asrk_pkg::rank_arr_t ranks
);
	import asrk_pkg::*;

	logic [NumWords-1:0][7:0] fold;

	always_comb begin
		for (int c = 0; c < NumWords; c++) begin
			fold[c] = fold_bytes(state_words[c] ^ key_words[c]);
		end
	end

	// rank = count of strictly smaller folds; ties share a rank
	always_comb begin
		for (int c = 0; c < NumWords; c++) begin
			ranks[c] = '0;
			for (int k = 0; k < NumWords; k++) begin
				ranks[c] = ranks[c] + RankW'(fold[k] < fold[c]);
			end
		end
	end

endmodule

// ----- design/asrk_permute.sv -----
// Byte permutation: AES row shifts across words, or rotation within each word.
// Depends on asrk_pkg.
module asrk_permute (
	input  asrk_pkg::word_arr_t state_words,
	input  asrk_pkg::rank_arr_t ranks,
	input  asrk_pkg::cfg_t      cfg,
	output asrk_pkg::word_arr_t out_words
);
	import asrk_pkg::*;

	always_comb begin
		logic [RankW-1:0] sel;
		logic [RankW-1:0] cc;
		logic [RankW-1:0] rr;
		out_words = '0;
		sel = '0;
		for (int c = 0; c < NumWords; c++) begin
			for (int r = 0; r < NumWords; r++) begin
				cc = RankW'(c);
				rr = RankW'(r);
				if (cfg.keyed_mode) begin
					sel = cfg.inverse ? rr - ranks[c] : rr + ranks[c];
					out_words[c][8*r +: 8] = state_words[c][{sel, 3'b000} +: 8];
				end else begin
					sel = cfg.inverse ? cc - rr : cc + rr;
					out_words[c][8*r +: 8] = state_words[sel][8*r +: 8];
				end
			end
		end
	end

endmodule

// ----- design/aes_shift_rows_keyed.sv -----
// AES ShiftRows with a key-dependent rotation mode; top level.
// Stages: input then result register; the permutation and 4-way rank fit in one stage.
// Throughput: one request per cycle, while result_ready does not stall the output.
// Reset: asynchronous, active low; clears valid bits and both config registers.
// Payload registers are not reset. Depends on asrk_pkg, asrk_rank, asrk_permute.
module aes_shift_rows_keyed (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  asrk_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output asrk_pkg::result_t   result,
	input  logic                cfg_we,
	input  asrk_pkg::cfg_idx_e  cfg_index,
	input  logic                cfg_data
);
	import asrk_pkg::*;

	cfg_t      cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	result_t   result_s2;
	logic      valid_s2;
	logic      advance;
	word_arr_t st_words;
	word_arr_t key_words;
	word_arr_t perm_words;
	rank_arr_t ranks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEYED_MODE: cfg_q.keyed_mode <= cfg_data;
				CFG_INVERSE:    cfg_q.inverse    <= cfg_data;
			endcase
		end
	end

	// result stage may load when empty or being drained
	assign advance    = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign st_words[0]  = item_s1.state_word_0;
	assign st_words[1]  = item_s1.state_word_1;
	assign st_words[2]  = item_s1.state_word_2;
	assign st_words[3]  = item_s1.state_word_3;
	assign key_words[0] = item_s1.key_word_0;
	assign key_words[1] = item_s1.key_word_1;
	assign key_words[2] = item_s1.key_word_2;
	assign key_words[3] = item_s1.key_word_3;

	asrk_rank u_rank (
		.state_words (st_words),
		.key_words   (key_words),
		.ranks       (ranks)
	);

	asrk_permute u_permute (
		.state_words (st_words),
		.ranks       (ranks),
		.cfg         (cfg_q),
		.out_words   (perm_words)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2.out_word_0 <= perm_words[0];
			result_s2.out_word_1 <= perm_words[1];
			result_s2.out_word_2 <= perm_words[2];
			result_s2.out_word_3 <= perm_words[3];
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("input stalled although result stage is free");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> result_valid)
		else $error("registered request did not reach the result stage");

	a_min_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (ranks[0] == '0 || ranks[1] == '0 || ranks[2] == '0
			|| ranks[3] == '0))
		else $error("no word holds the smallest rank");

	// rotation within a word keeps its byte fold
	a_keyed_fold_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && cfg_q.keyed_mode) |=>
		fold_bytes(result.out_word_2) == $past(fold_bytes(item_s1.state_word_2)))
		else $error("keyed rotation altered the bytes of a word");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for aes_shift_rows_keyed: standard and keyed row shifts,
// both directions, with random flow control on both channels.
// Depends on asrk_pkg and the design sources only.
`timescale 1ns / 1ps

module testbench;
	import asrk_pkg::*;

	localparam int unsigned LATENCY     = 2;
	localparam int unsigned HOLD_CYCLES = 100;
	localparam int unsigned WATCHDOG    = 4000;
	localparam int unsigned PHASE_ITEMS = 165;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_we;
	cfg_idx_e   cfg_index;
	logic       cfg_data;

	// shadow copy of the block's registers
	logic       keyed_q;
	logic       inverse_q;

	result_t    pending_perm[$];
	int unsigned errors;
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_settings;
	int unsigned idle_cycles;
	bit         tx_steady;
	bit         rx_steady;
	bit         hold_off;

	aes_shift_rows_keyed u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [7:0] xor_bytes(input logic [31:0] w);
		return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
	endfunction

	// Expected permutation of one request under the current register copy
	function automatic result_t permute_state(input item_t it);
		word_arr_t st;
		word_arr_t key;
		word_arr_t res;
		logic [7:0] fold [4];
		int unsigned rank [4];
		logic [1:0] src;
		st  = {it.state_word_3, it.state_word_2, it.state_word_1, it.state_word_0};
		key = {it.key_word_3, it.key_word_2, it.key_word_1, it.key_word_0};
		res = '0;
		for (int c = 0; c < 4; c++)
			fold[c] = xor_bytes(st[c] ^ key[c]);
		for (int c = 0; c < 4; c++) begin
			rank[c] = 0;
			for (int k = 0; k < 4; k++)
				if (fold[k] < fold[c])
					rank[c]++;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!keyed_q) begin
					src = inverse_q ? 2'(c - r) : 2'(c + r);
					res[c][8*r +: 8] = st[src][8*r +: 8];
				end else begin
					src = inverse_q ? 2'(r - int'(rank[c])) : 2'(r + int'(rank[c]));
					res[c][8*r +: 8] = st[c][8*src +: 8];
				end
			end
		end
		return result_t'{res[0], res[1], res[2], res[3]};
	endfunction

	// Picks key words so that word k's state^key fold equals folds[k]
	function automatic item_t steer_folds(input word_arr_t st, input logic [3:0][7:0] folds,
			input logic [3:0][23:0] key_hi);
		word_arr_t key;
		for (int k = 0; k < 4; k++)
			key[k] = {key_hi[k], folds[k] ^ xor_bytes(st[k])
				^ key_hi[k][7:0] ^ key_hi[k][15:8] ^ key_hi[k][23:16]};
		return item_t'{st[0], st[1], st[2], st[3], key[0], key[1], key[2], key[3]};
	endfunction

	function automatic item_t random_item();
		word_arr_t st;
		logic [3:0][7:0] folds;
		logic [7:0] base;
		logic [3:0][23:0] hi;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 11))
				0:       st[k] = '0;
				1:       st[k] = '1;
				default: st[k] = $urandom;
			endcase
		end
		if (keyed_q && $urandom_range(0, 1)) begin
			// small pool of fold values so that ties are common
			base = 8'($urandom);
			for (int k = 0; k < 4; k++) begin
				case ($urandom_range(0, 3))
					0:       folds[k] = 8'h00;
					1:       folds[k] = 8'hFF;
					2:       folds[k] = base;
					default: folds[k] = base ^ 8'h01;
				endcase
				hi[k] = 24'($urandom);
			end
			return steer_folds(st, folds, hi);
		end
		return item_t'{st[0], st[1], st[2], st[3], $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Offers one request, after a random gap unless tx_steady, and waits for it to be taken
	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!(item_valid && item_ready));
	endtask

	// Stops offering and waits for every outstanding result
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_perm.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_mode(input logic keyed, input logic inv);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEYED_MODE;
		cfg_data  <= keyed;
		@(negedge clk);
		cfg_index <= CFG_INVERSE;
		cfg_data  <= inv;
		@(negedge clk);
		cfg_we    <= 1'b0;
		keyed_q   = keyed;
		inverse_q = inv;
		n_settings++;
	endtask

	task automatic test_standard_shift();
		for (int i = 0; i < 2; i++) begin
			set_mode(1'b0, logic'(i));
			send_item('0);
			send_item('1);
			send_item(item_t'{32'h03020100, 32'h13121110, 32'h23222120, 32'h33323130,
				$urandom, $urandom, $urandom, $urandom});
			send_item(item_t'{32'hAA55AA55, 32'h55AA55AA, 32'hFF0000FF, 32'h00FFFF00,
				'1, '0, '1, '0});
			drain();
		end
	endtask

	task automatic test_keyed_ranks();
		word_arr_t st;
		st = {32'h33323130, 32'h23222120, 32'h13121110, 32'h03020100};
		for (int i = 0; i < 2; i++) begin
			set_mode(1'b1, logic'(i));
			// fold words packed word 3 first
			send_item('0);                                          // all tied at zero
			send_item(steer_folds(st, 32'hFF_80_40_00, '0));        // ranks ascending
			send_item(steer_folds(st, 32'h00_40_80_FF, '0));        // ranks descending
			send_item(steer_folds(st, 32'h10_10_20_20, '1));        // two tied pairs
			send_item(steer_folds(st, 32'h55_55_55_01, '0));        // three tied above one
			send_item(steer_folds(st, 32'hFF_FF_FF_FF, '1));        // all tied at top
			drain();
		end
	endtask

	task automatic test_backpressure();
		set_mode(1'b1, 1'b0);
		tx_steady = 1'b1;
		hold_off  = 1'b1;
		for (int i = 0; i < 24; i++)
			send_item(random_item());
		tx_steady = 1'b0;
		drain();
	endtask

	task automatic test_random_mix();
		logic [1:0] modes [6];
		modes = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b10, 2'b00};
		foreach (modes[p]) begin
			set_mode(modes[p][1], modes[p][0]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 39) == 0)
					tx_steady = ~tx_steady;
				if ($urandom_range(0, 39) == 0)
					rx_steady = ~rx_steady;
				// sender pauses mid-phase until the block is empty
				if (i == PHASE_ITEMS / 2)
					drain();
				send_item(random_item());
			end
			drain();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int unsigned pause;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
			pause = rx_steady ? 0 : $urandom_range(0, 12);
			if (pause > 0) begin
				result_ready <= 1'b0;
				repeat (pause) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) begin
			pending_perm.push_back(permute_state(item));
			n_sent++;
		end
	end

	always @(posedge clk) begin
		result_t want;
		word_arr_t want_w;
		word_arr_t got_w;
		if (arst_n && result_valid && result_ready) begin
			if (pending_perm.size() == 0) begin
				$display("%t: result %h with no request outstanding", $realtime, result);
				errors++;
			end else begin
				want   = pending_perm.pop_front();
				want_w = {want.out_word_3, want.out_word_2, want.out_word_1, want.out_word_0};
				got_w  = {result.out_word_3, result.out_word_2, result.out_word_1,
					result.out_word_0};
				for (int k = 0; k < 4; k++)
					if (got_w[k] !== want_w[k]) begin
						$display("%t: out_word_%0d expected %h actual %h (keyed %0b inv %0b)",
							$realtime, k, want_w[k], got_w[k], keyed_q, inverse_q);
						errors++;
					end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_perm.size());
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_KEYED_MODE;
		cfg_data    = 1'b0;
		keyed_q     = 1'b0;
		inverse_q   = 1'b0;
		errors      = 0;
		n_sent      = 0;
		n_checked   = 0;
		n_settings  = 0;
		idle_cycles = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		hold_off    = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_standard_shift();
		test_keyed_ranks();
		test_backpressure();
		test_random_mix();

		drain();
		repeat (8) @(posedge clk);
		errors += pending_perm.size();
		$display("testbench: %0d requests, %0d results checked over %0d register settings",
			n_sent, n_checked, n_settings);
		$display("testbench: both shift modes each way, tied ranks, long stall and drains");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- aes_shift_rows_keyed.f -----
design/asrk_pkg.sv
design/asrk_rank.sv
design/asrk_permute.sv
design/aes_shift_rows_keyed.sv
tb/testbench.sv
